// File: rtl/pbr_pkg.sv
// Shared constants and types for the polyline rasterizer.
// No dependencies; every other file refers to this package by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package pbr_pkg;

   // Grid geometry; coordinate width is fixed by the vertex and pixel fields.
   localparam int unsigned GRID_SIZE = 64;
   localparam int unsigned COORD_W = 6;
   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

   // Decision value spans [-2*major, 2*major), step count spans [1, GRID_SIZE].
   localparam int unsigned ERR_W = COORD_W + 3;
   localparam int unsigned STEP_W = COORD_W + 1;

   // Segment queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // One line segment, set up and ready to walk.
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic               neg_x;   // x steps toward smaller columns
      logic               neg_y;   // y steps toward smaller rows
      logic               steep;   // y is the major axis
      logic [COORD_W-1:0] major;
      logic [COORD_W-1:0] minor;
   } seg_type;

endpackage

`default_nettype wire

// File: rtl/pbr_if.sv
// Valid/ready channel interfaces for vertex words and pixel words.
// Depends on pbr_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface pbr_vertex_if;
   logic                        valid;
   logic                        ready;
   logic [pbr_pkg::COORD_W-1:0] vertex_x;
   logic [pbr_pkg::COORD_W-1:0] vertex_y;
   logic                        start_new_path;

   modport source (output valid, output vertex_x, output vertex_y,
                   output start_new_path, input ready);
   modport sink (input valid, input vertex_x, input vertex_y,
                 input start_new_path, output ready);
endinterface

interface pbr_pixel_if;
   logic                        valid;
   logic                        ready;
   logic [pbr_pkg::COORD_W-1:0] pixel_x;
   logic [pbr_pkg::COORD_W-1:0] pixel_y;
   logic                        last_pixel;

   modport source (output valid, output pixel_x, output pixel_y,
                   output last_pixel, input ready);
   modport sink (input valid, input pixel_x, input pixel_y,
                 input last_pixel, output ready);
endinterface

`default_nettype wire

// File: rtl/pbr_front.sv
// Front: takes vertex words, keeps the stored vertex and sets up segments.
// Depends on pbr_pkg and pbr_vertex_if.
`timescale 1ns / 1ps
`default_nettype none

module pbr_front (
   input  wire logic          clock,
   input  wire logic          reset,
   pbr_vertex_if.sink         req,
   output pbr_pkg::seg_type   seg_data,
   output logic               seg_push,
   input  wire logic          seg_room
);

   logic [pbr_pkg::COORD_W-1:0] stored_x_ff, stored_x_in;
   logic [pbr_pkg::COORD_W-1:0] stored_y_ff, stored_y_in;
   logic                        have_stored_ff, have_stored_in;

   logic [pbr_pkg::COORD_W-1:0] vx, vy;
   logic [pbr_pkg::COORD_W-1:0] adx, ady;
   logic                        neg_x, neg_y, steep;
   logic                        accept, draw;

   // Saturate coordinates beyond the grid
   assign vx = (req.vertex_x > pbr_pkg::COORD_MAX) ? pbr_pkg::COORD_MAX : req.vertex_x;
   assign vy = (req.vertex_y > pbr_pkg::COORD_MAX) ? pbr_pkg::COORD_MAX : req.vertex_y;

   // Take a word whenever the queue has room
   assign req.ready = seg_room;
   assign accept    = req.valid && seg_room;
   assign draw      = have_stored_ff && !req.start_new_path;

   // Set up the segment from the stored vertex to the new one
   always_comb begin
      neg_x = vx < stored_x_ff;
      neg_y = vy < stored_y_ff;
      adx   = neg_x ? (stored_x_ff - vx) : (vx - stored_x_ff);
      ady   = neg_y ? (stored_y_ff - vy) : (vy - stored_y_ff);
      steep = ady > adx;
   end

   always_comb begin
      seg_data.start_x = stored_x_ff;
      seg_data.start_y = stored_y_ff;
      seg_data.neg_x   = neg_x;
      seg_data.neg_y   = neg_y;
      seg_data.steep   = steep;
      seg_data.major   = steep ? ady : adx;
      seg_data.minor   = steep ? adx : ady;
   end

   assign seg_push = accept && draw;

   // Every accepted vertex becomes the stored vertex
   always_comb begin
      stored_x_in    = stored_x_ff;
      stored_y_in    = stored_y_ff;
      have_stored_in = have_stored_ff;
      if (accept) begin
         stored_x_in    = vx;
         stored_y_in    = vy;
         have_stored_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_x_ff    <= '0;
         stored_y_ff    <= '0;
         have_stored_ff <= 1'b0;
      end else begin
         stored_x_ff    <= stored_x_in;
         stored_y_ff    <= stored_y_in;
         have_stored_ff <= have_stored_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pbr_seg_queue.sv
// Short register queue of set-up segments between front and back.
// Depends on pbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbr_seg_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pbr_pkg::seg_type  push_data,
   output logic                   room,
   input  wire logic              pop,
   output pbr_pkg::seg_type       pop_data,
   output logic                   filled
);

   pbr_pkg::seg_type entry_ff [pbr_pkg::QUEUE_DEPTH];
   logic [pbr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pbr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pbr_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign room     = count_ff != pbr_pkg::QCNT_W'(pbr_pkg::QUEUE_DEPTH);
   assign filled   = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && room;
   assign do_pop   = pop && filled;

   // Advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pbr_pkg::QPTR_W'(pbr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pbr_pkg::QPTR_W'(pbr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload entries; no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pbr_back.sv
// Back: Bresenham segment walk, one pixel word a cycle unless stalled.
// Depends on pbr_pkg and pbr_pixel_if.
`timescale 1ns / 1ps
`default_nettype none

module pbr_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pbr_pkg::seg_type  seg_data,
   input  wire logic              seg_filled,
   output logic                   seg_pop,
   pbr_pixel_if.source            rsp
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   localparam int unsigned CW = pbr_pkg::COORD_W;
   localparam int unsigned EW = pbr_pkg::ERR_W;
   localparam int unsigned SW = pbr_pkg::STEP_W;

   state_type        state_ff;
   logic [CW-1:0]    walk_x_ff, walk_y_ff;
   logic [EW-1:0]    err_ff;
   logic [SW-1:0]    steps_ff;
   logic             steep_ff, neg_x_ff, neg_y_ff;
   logic [EW-1:0]    two_major_ff, two_minor_ff;
   logic             rsp_valid_ff;
   logic [CW-1:0]    pixel_x_ff, pixel_y_ff;
   logic             last_ff;

   logic             emit, last_step, err_ge;
   logic             move_x, move_y;
   logic [CW-1:0]    walk_x_in, walk_y_in;
   logic [EW-1:0]    err_in;
   logic [EW-1:0]    init_err;
   logic [EW-1:0]    seg_two_minor;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_x    = pixel_x_ff;
   assign rsp.pixel_y    = pixel_y_ff;
   assign rsp.last_pixel = last_ff;

   // Load a segment only from idle
   assign seg_pop = (state_ff == ST_IDLE) && seg_filled;

   // Emit when the output register is free or being drained
   assign emit      = (state_ff == ST_WALK) && (!rsp_valid_ff || rsp.ready);
   assign last_step = steps_ff == SW'(1);

   // Bresenham step: minor axis moves on a non-negative decision value
   always_comb begin
      err_ge    = !err_ff[EW-1];
      move_x    = steep_ff ? err_ge : 1'b1;
      move_y    = steep_ff ? 1'b1 : err_ge;
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      if (move_x) begin
         walk_x_in = neg_x_ff ? (walk_x_ff - 1'b1) : (walk_x_ff + 1'b1);
      end
      if (move_y) begin
         walk_y_in = neg_y_ff ? (walk_y_ff - 1'b1) : (walk_y_ff + 1'b1);
      end
      err_in = (err_ge ? (err_ff - two_major_ff) : err_ff) + two_minor_ff;
   end

   // Initial decision value 2*minor - major
   assign seg_two_minor = {2'b00, seg_data.minor, 1'b0};
   assign init_err      = seg_two_minor - {3'b000, seg_data.major};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (seg_filled) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (emit) begin
                  rsp_valid_ff <= 1'b1;
                  if (last_step) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Hold walk registers and the output word
   always_ff @(posedge clock) begin
      if (seg_pop) begin
         walk_x_ff    <= seg_data.start_x;
         walk_y_ff    <= seg_data.start_y;
         err_ff       <= init_err;
         steps_ff     <= {1'b0, seg_data.major} + 1'b1;
         steep_ff     <= seg_data.steep;
         neg_x_ff     <= seg_data.neg_x;
         neg_y_ff     <= seg_data.neg_y;
         two_major_ff <= {2'b00, seg_data.major, 1'b0};
         two_minor_ff <= seg_two_minor;
      end else if (emit) begin
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         err_ff    <= err_in;
         steps_ff  <= steps_ff - 1'b1;
      end
      if (emit) begin
         pixel_x_ff <= walk_x_ff;
         pixel_y_ff <= walk_y_ff;
         last_ff    <= last_step;
      end
   end

endmodule

`default_nettype wire

// File: rtl/polyline_bresenham_rasterizer.sv
// Polyline rasterizer: vertex words in, one pixel word per plotted grid cell out,
// the end pixel of each segment marked. A vertex that starts a new path, or that
// arrives with no vertex stored, is stored and draws nothing; any other vertex
// draws the line from the stored vertex to itself. The back walks one pixel per
// cycle while the output is not stalled: a segment whose longer axis spans m
// steps gives m+1 pixel words after a queue load. The front takes a
// vertex word each cycle while the two-entry segment queue has room.
// Coordinates above the grid edge are saturated to the last row or column.
`timescale 1ns / 1ps
`default_nettype none

module polyline_bresenham_rasterizer (
   input  wire logic    clock,
   input  wire logic    reset,
   pbr_vertex_if.sink   req_vertex,
   pbr_pixel_if.source  rsp_pixel
);

   pbr_pkg::seg_type push_data, pop_data;
   logic             push, room, pop, filled;

   // Accept and classify vertices
   pbr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_vertex),
      .seg_data (push_data),
      .seg_push (push),
      .seg_room (room)
   );

   // Decouple setup from the walk
   pbr_seg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .pop       (pop),
      .pop_data  (pop_data),
      .filled    (filled)
   );

   // Walk segments into pixel words
   pbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seg_data   (pop_data),
      .seg_filled (filled),
      .seg_pop    (pop),
      .rsp        (rsp_pixel)
   );

endmodule

`default_nettype wire

// File: tb/tb_polyline_bresenham_rasterizer.sv
// Self-checking bench for the polyline rasterizer: vertex words in, pixel words checked.
// Depends on pbr_pkg, the channel interfaces in pbr_if and the rasterizer RTL.
`timescale 1ns / 1ps

module tb_polyline_bresenham_rasterizer;

   localparam int unsigned CW = pbr_pkg::COORD_W;

   typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          last;
   } pixel_word_type;

   // Tracks the stored vertex, predicts every pixel word of a segment and checks arrivals.
   class pixel_scoreboard_type;
      logic [CW-1:0]  anchor_x;
      logic [CW-1:0]  anchor_y;
      bit             have_anchor;
      pixel_word_type pending_pixels[$];
      int             mismatches;

      function new();
         anchor_x = '0;
         anchor_y = '0;
         have_anchor = 0;
         mismatches = 0;
      endfunction

      // Record one accepted vertex word; queue the pixels of its segment, if any.
      function void plot_segment(logic [CW-1:0] vx, logic [CW-1:0] vy, logic new_path);
         int dx, dy, sx, sy, major, minor, err, wx, wy;
         bit steep;
         pixel_word_type p;
         if (new_path || !have_anchor) begin
            anchor_x = vx;
            anchor_y = vy;
            have_anchor = 1;
            return;
         end
         dx = (vx > anchor_x) ? int'(vx) - int'(anchor_x) : int'(anchor_x) - int'(vx);
         dy = (vy > anchor_y) ? int'(vy) - int'(anchor_y) : int'(anchor_y) - int'(vy);
         sx = (vx > anchor_x) ? 1 : ((vx < anchor_x) ? -1 : 0);
         sy = (vy > anchor_y) ? 1 : ((vy < anchor_y) ? -1 : 0);
         steep = dy > dx;
         major = steep ? dy : dx;
         minor = steep ? dx : dy;
         err = 2 * minor - major;
         wx = int'(anchor_x);
         wy = int'(anchor_y);
         for (int i = 0; i <= major; i++) begin
            p.x = wx[CW-1:0];
            p.y = wy[CW-1:0];
            p.last = (i == major);
            pending_pixels.push_back(p);
            // advance the walk: minor axis while the decision is non-negative, then major
            if (i != major) begin
               while (err >= 0) begin
                  err -= 2 * major;
                  if (steep) wx += sx;
                  else wy += sy;
               end
               err += 2 * minor;
               if (steep) wy += sy;
               else wx += sx;
            end
         end
         anchor_x = vx;
         anchor_y = vy;
      endfunction

      // Compare one accepted pixel word with the oldest prediction.
      function void check_pixel(logic [CW-1:0] px, logic [CW-1:0] py, logic last);
         pixel_word_type e;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected pixel x=%0d y=%0d last=%0b", px, py, last);
            return;
         end
         e = pending_pixels.pop_front();
         if (px !== e.x || py !== e.y || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: pixel expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                        e.x, e.y, e.last, px, py, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   pixel_scoreboard_type board;

   pbr_vertex_if req_vertex();
   pbr_pixel_if  rsp_pixel();

   polyline_bresenham_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_vertex (req_vertex),
      .rsp_pixel  (rsp_pixel)
   );

   // Free-running 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if the block hangs.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Drive the pixel ready at the falling edge, stalling at the current rate.
   always @(negedge clock) begin
      if (reset) rsp_pixel.ready = 1'b0;
      else rsp_pixel.ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Check every pixel word accepted at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_pixel.valid === 1'b1 && rsp_pixel.ready === 1'b1)
         board.check_pixel(rsp_pixel.pixel_x, rsp_pixel.pixel_y, rsp_pixel.last_pixel);
   end

   // Present one vertex word after random idle cycles; hold it until accepted.
   task automatic send_vertex(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                              input logic new_path);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_vertex.valid = 1'b0;
         @(negedge clock);
      end
      req_vertex.valid = 1'b1;
      req_vertex.vertex_x = vx;
      req_vertex.vertex_y = vy;
      req_vertex.start_new_path = new_path;
      do @(posedge clock); while (req_vertex.ready !== 1'b1);
      board.plot_segment(vx, vy, new_path);
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted pixel has arrived.
   task automatic wait_drain();
      req_vertex.valid = 1'b0;
      while (board.pending_pixels.size() != 0) @(negedge clock);
   endtask

   // Random vertices: mostly segments, some near the stored vertex, some on the grid edges.
   task automatic send_random(input int count);
      logic [CW-1:0] vx, vy;
      logic np;
      int mode;
      for (int i = 0; i < count; i++) begin
         np = ($urandom_range(0, 9) == 0);
         mode = $urandom_range(0, 3);
         if (mode == 0) begin
            vx = CW'(int'(board.anchor_x) + $urandom_range(0, 10) - 5);
            vy = CW'(int'(board.anchor_y) + $urandom_range(0, 10) - 5);
         end else if (mode == 1) begin
            vx = $urandom_range(0, 2) == 0 ? CW'($urandom) :
                 ($urandom_range(0, 1) ? pbr_pkg::COORD_MAX : '0);
            vy = $urandom_range(0, 2) == 0 ? CW'($urandom) :
                 ($urandom_range(0, 1) ? pbr_pkg::COORD_MAX : '0);
         end else begin
            vx = CW'($urandom);
            vy = CW'($urandom);
         end
         send_vertex(vx, vy, np);
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_vertex.valid = 1'b0;
      req_vertex.vertex_x = '0;
      req_vertex.vertex_y = '0;
      req_vertex.start_new_path = 1'b0;
      rsp_pixel.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: nothing stored, repeated vertex, all octants, grid extremes, new paths.
      send_vertex(6'd10, 6'd20, 1'b0);
      send_vertex(6'd10, 6'd20, 1'b0);
      send_vertex(6'd30, 6'd25, 1'b0);
      send_vertex(6'd33, 6'd45, 1'b0);
      send_vertex(6'd30, 6'd60, 1'b0);
      send_vertex(6'd10, 6'd55, 1'b0);
      send_vertex(6'd8, 6'd40, 1'b0);
      send_vertex(6'd12, 6'd30, 1'b0);
      send_vertex(6'd40, 6'd22, 1'b0);
      send_vertex(6'd40, 6'd22, 1'b1);
      send_vertex(6'd0, 6'd0, 1'b1);
      send_vertex(6'd63, 6'd63, 1'b0);
      send_vertex(6'd0, 6'd63, 1'b0);
      send_vertex(6'd0, 6'd0, 1'b0);
      send_vertex(6'd63, 6'd0, 1'b0);
      send_vertex(6'd0, 6'd63, 1'b0);
      send_vertex(6'd63, 6'd63, 1'b1);
      send_vertex(6'd63, 6'd63, 1'b0);
      send_vertex(6'd62, 6'd0, 1'b0);
      send_vertex(6'd0, 6'd1, 1'b0);
      send_vertex(6'd40, 6'd10, 1'b0);
      send_vertex(6'd2, 6'd20, 1'b0);
      send_vertex(6'd63, 6'd0, 1'b0);
      wait_drain();

      // Random phases: no idling, sender idle, receiver stall, both light.
      send_random(120);
      wait_drain();
      send_idle_pct = 66;
      send_random(120);
      wait_drain();
      send_idle_pct = 0;
      recv_stall_pct = 66;
      send_random(120);
      wait_drain();
      send_idle_pct = 11;
      recv_stall_pct = 11;
      send_random(120);
      wait_drain();

      // Let any stray pixel words show up before the verdict.
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
